@@ design/v3a_pkg.sv @@
// Shared types and constants for the Q-format 3D vector unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package v3a_pkg;

    localparam int V3A_FRAC_BITS = 16;
    // root stages: one result bit each
    localparam int ISQRT_STAGES = 32;
    // divide stages: range check plus one quotient bit each
    localparam int DIV_QBITS = 33;
    localparam int DIV_STAGES = DIV_QBITS + 1;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_NEG   = 4'd2,
        OP_SCALE = 4'd3,
        OP_DIV   = 4'd4,
        OP_DOT   = 4'd5,
        OP_CROSS = 4'd6,
        OP_MAG   = 4'd7,
        OP_MAGSQ = 4'd8,
        OP_NORM  = 4'd9
    } op_t;

    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_DIV0 = 2'd1;
    localparam logic [1:0] FAULT_OVF  = 2'd2;

    // request fields carried beside the root and divide pipelines
    typedef struct packed {
        logic [3:0]       kind;
        logic [2:0][31:0] vec;
        logic [31:0]      scl;
        logic             ovf;
        logic             div0;
        logic [2:0][31:0] amag;
        logic [2:0]       aneg;
        logic [31:0]      smag;
        logic             sneg;
    } side_t;

endpackage

`default_nettype wire

@@ design/vector3_fixed_point_alu.sv @@
// Top level of the 3D fixed-point vector unit: multiply, sum, saturate,
// root and divide pipelines. Depends on v3a_pkg, v3a_isqrt, v3a_div.
//
//  channel | dir | handshake         | payload
//  s_      | in  | s_tvalid/s_tready | s_tdata: a_x a_y a_z b_x b_y b_z scale_factor
//          |     |                   | s_tuser: kind
//  m_      | out | m_tvalid/m_tready | m_tdata: res_x res_y res_z res_scalar
//          |     |                   | m_tuser: fault
//
// One request enters per cycle while the pipeline advances; each request passes
// through 4 arithmetic stages, 32 root stages and 34 divide stages, then the
// output register. The whole pipeline advances together whenever the output
// register is empty or being taken; otherwise it holds.
// Reset clears the valid bits only.
`default_nettype none

module vector3_fixed_point_alu #(
    parameter int FRAC_BITS = v3a_pkg::V3A_FRAC_BITS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [31:0] a_x, [63:32] a_y, [95:64] a_z, [127:96] b_x, [159:128] b_y,
    // [191:160] b_z, [223:192] scale_factor
    input  wire logic [223:0] s_tdata,
    // [3:0] kind
    input  wire logic [3:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] res_x, [63:32] res_y, [95:64] res_z, [127:96] res_scalar
    output logic [127:0]      m_tdata,
    // [1:0] fault
    output logic [1:0]        m_tuser
);
    import v3a_pkg::*;

    localparam int DEPTH = 4 + ISQRT_STAGES + DIV_STAGES;
    localparam logic signed [66:0] HALF = 67'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [66:0] MAXW = 67'sd2147483647;
    localparam logic signed [66:0] MINW = -67'sd2147483648;

    function automatic logic signed [66:0] rnd(input logic signed [66:0] v);
        rnd = (v + HALF) >>> FRAC_BITS;
    endfunction

    // returns {overflow, value}
    function automatic logic [32:0] sat(input logic signed [66:0] v);
        if (v > MAXW)
            sat = {1'b1, 32'h7FFF_FFFF};
        else if (v < MINW)
            sat = {1'b1, 32'h8000_0000};
        else
            sat = {1'b0, v[31:0]};
    endfunction

    logic adv;
    logic vld_reg [DEPTH];
    logic out_vld_reg;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                vld_reg[i] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < DEPTH; i++)
                vld_reg[i] <= vld_reg[i-1];
            out_vld_reg <= vld_reg[DEPTH-1];
        end
    end

    // stage 1: capture request
    logic [3:0]         kind1_reg;
    logic signed [31:0] a1_reg [3];
    logic signed [31:0] b1_reg [3];
    logic signed [31:0] s1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind1_reg <= s_tuser;
            for (int i = 0; i < 3; i++)
            begin
                a1_reg[i] <= s_tdata[32*i +: 32];
                b1_reg[i] <= s_tdata[96 + 32*i +: 32];
            end
            s1_reg <= s_tdata[192 +: 32];
        end
    end

    // stage 2: products and add/sub/negate
    logic signed [31:0] ml [6];
    logic signed [31:0] mr [6];
    logic signed [32:0] e2_next [3];
    logic [3:0]         kind2_reg;
    logic signed [31:0] a2_reg [3];
    logic signed [31:0] s2_reg;
    logic signed [63:0] p2_reg [6];
    logic signed [32:0] e2_reg [3];

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            ml[i] = '0;
            mr[i] = '0;
        end
        for (int i = 0; i < 3; i++)
            e2_next[i] = '0;
        case (kind1_reg)
            OP_ADD:
                for (int i = 0; i < 3; i++)
                    e2_next[i] = a1_reg[i] + b1_reg[i];
            OP_SUB:
                for (int i = 0; i < 3; i++)
                    e2_next[i] = a1_reg[i] - b1_reg[i];
            OP_NEG:
                for (int i = 0; i < 3; i++)
                    e2_next[i] = 33'sd0 - a1_reg[i];
            OP_SCALE:
                for (int i = 0; i < 3; i++)
                begin
                    ml[i] = a1_reg[i];
                    mr[i] = s1_reg;
                end
            OP_DOT:
                for (int i = 0; i < 3; i++)
                begin
                    ml[i] = a1_reg[i];
                    mr[i] = b1_reg[i];
                end
            OP_MAG, OP_MAGSQ, OP_NORM:
                for (int i = 0; i < 3; i++)
                begin
                    ml[i] = a1_reg[i];
                    mr[i] = a1_reg[i];
                end
            OP_CROSS:
            begin
                ml[0] = a1_reg[1]; mr[0] = b1_reg[2];
                ml[1] = a1_reg[2]; mr[1] = b1_reg[1];
                ml[2] = a1_reg[2]; mr[2] = b1_reg[0];
                ml[3] = a1_reg[0]; mr[3] = b1_reg[2];
                ml[4] = a1_reg[0]; mr[4] = b1_reg[1];
                ml[5] = a1_reg[1]; mr[5] = b1_reg[0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind2_reg <= kind1_reg;
            s2_reg    <= s1_reg;
            for (int i = 0; i < 3; i++)
            begin
                a2_reg[i] <= a1_reg[i];
                e2_reg[i] <= e2_next[i];
            end
            for (int i = 0; i < 6; i++)
                p2_reg[i] <= ml[i] * mr[i];
        end
    end

    // stage 3: exact sums, rounded
    logic signed [66:0] w3_next [3];
    logic signed [66:0] ws3_next;
    logic signed [66:0] sum3;
    logic [3:0]         kind3_reg;
    logic signed [31:0] a3_reg [3];
    logic signed [31:0] s3_reg;
    logic signed [66:0] w3_reg [3];
    logic signed [66:0] ws3_reg;
    logic [63:0]        ss3_reg;

    assign sum3 = 67'(p2_reg[0]) + 67'(p2_reg[1]) + 67'(p2_reg[2]);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            w3_next[i] = '0;
        ws3_next = '0;
        case (kind2_reg)
            OP_ADD, OP_SUB, OP_NEG:
                for (int i = 0; i < 3; i++)
                    w3_next[i] = 67'(e2_reg[i]);
            OP_SCALE:
                for (int i = 0; i < 3; i++)
                    w3_next[i] = rnd(67'(p2_reg[i]));
            OP_CROSS:
                for (int i = 0; i < 3; i++)
                    w3_next[i] = rnd(67'(p2_reg[2*i]) - 67'(p2_reg[2*i+1]));
            OP_DOT, OP_MAGSQ:
                ws3_next = rnd(sum3);
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kind3_reg <= kind2_reg;
            s3_reg    <= s2_reg;
            for (int i = 0; i < 3; i++)
            begin
                a3_reg[i] <= a2_reg[i];
                w3_reg[i] <= w3_next[i];
            end
            ws3_reg <= ws3_next;
            ss3_reg <= sum3[63:0];
        end
    end

    // stage 4: saturate, split signs and magnitudes
    side_t       side4_next;
    side_t       side4_reg;
    logic [63:0] ss4_reg;
    logic [32:0] sv [3];
    logic [32:0] ssc;

    always_comb
    begin
        ssc = sat(ws3_reg);
        side4_next.kind = kind3_reg;
        side4_next.scl  = ssc[31:0];
        side4_next.div0 = 1'b0;
        side4_next.sneg = s3_reg[31];
        side4_next.smag = s3_reg[31] ? 32'(-s3_reg) : s3_reg;
        for (int i = 0; i < 3; i++)
        begin
            sv[i] = sat(w3_reg[i]);
            side4_next.vec[i]  = sv[i][31:0];
            side4_next.aneg[i] = a3_reg[i][31];
            side4_next.amag[i] = a3_reg[i][31] ? 32'(-a3_reg[i]) : a3_reg[i];
        end
        side4_next.ovf = ssc[32] | sv[0][32] | sv[1][32] | sv[2][32];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side4_reg <= side4_next;
            ss4_reg   <= ss3_reg;
        end
    end

    // square root stages
    logic [31:0] root;
    side_t       side_i_reg [ISQRT_STAGES];

    v3a_isqrt u_isqrt (
        .clk  (clk),
        .en   (adv),
        .x    (ss4_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_i_reg[0] <= side4_reg;
            for (int i = 1; i < ISQRT_STAGES; i++)
                side_i_reg[i] <= side_i_reg[i-1];
        end
    end

    // divide entry: pick divisor, finish magnitude, flag zero divisor
    side_t       side_e;
    side_t       side_d_reg [DIV_STAGES];
    logic [31:0] dvs;
    logic [DIV_QBITS-1:0] q [3];
    logic                 big [3];

    always_comb
    begin
        side_e = side_i_reg[ISQRT_STAGES-1];
        dvs    = (side_e.kind == OP_NORM) ? root : side_e.smag;
        if (side_e.kind == OP_MAG)
        begin
            if (root[31])
            begin
                side_e.scl = 32'h7FFF_FFFF;
                side_e.ovf = 1'b1;
            end
            else
                side_e.scl = root;
        end
        side_e.div0 = (side_e.kind == OP_DIV || side_e.kind == OP_NORM) && (dvs == 32'd0);
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        v3a_div u_div (
            .clk (clk),
            .en  (adv),
            .n   ({32'd0, side_e.amag[g]} << FRAC_BITS),
            .d   (dvs),
            .q   (q[g]),
            .big (big[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_d_reg[0] <= side_e;
            for (int i = 1; i < DIV_STAGES; i++)
                side_d_reg[i] <= side_d_reg[i-1];
        end
    end

    // final select and signed saturation of quotients
    side_t       sf;
    logic        qneg [3];
    logic        qovf;
    logic [31:0] qv [3];
    logic [127:0] data_next;
    logic [1:0]   fault_next;
    logic [127:0] data_reg;
    logic [1:0]   fault_reg;

    always_comb
    begin
        sf   = side_d_reg[DIV_STAGES-1];
        qovf = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            qneg[i] = (sf.kind == OP_DIV) ? (sf.aneg[i] ^ sf.sneg) : sf.aneg[i];
            if (qneg[i])
            begin
                if (big[i] || q[i] > 33'h0_8000_0000)
                begin
                    qv[i] = 32'h8000_0000;
                    qovf  = 1'b1;
                end
                else
                    qv[i] = 32'(33'd0 - q[i]);
            end
            else
            begin
                if (big[i] || q[i] > 33'h0_7FFF_FFFF)
                begin
                    qv[i] = 32'h7FFF_FFFF;
                    qovf  = 1'b1;
                end
                else
                    qv[i] = q[i][31:0];
            end
        end

        if (sf.div0)
        begin
            data_next  = '0;
            fault_next = FAULT_DIV0;
        end
        else if (sf.kind == OP_DIV || sf.kind == OP_NORM)
        begin
            data_next  = {32'd0, qv[2], qv[1], qv[0]};
            fault_next = qovf ? FAULT_OVF : FAULT_NONE;
        end
        else
        begin
            data_next  = {sf.scl, sf.vec[2], sf.vec[1], sf.vec[0]};
            fault_next = sf.ovf ? FAULT_OVF : FAULT_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg  <= data_next;
            fault_reg <= fault_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = fault_reg;

endmodule

`default_nettype wire

@@ design/v3a_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
// Depends on v3a_pkg for the stage count.
`default_nettype none

module v3a_isqrt (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] x,
    output logic      [31:0] root
);
    import v3a_pkg::*;

    logic [63:0] x_reg [ISQRT_STAGES];
    logic [63:0] r_reg [ISQRT_STAGES];

    for (genvar k = 0; k < ISQRT_STAGES; k++) begin : g_stage
        logic [63:0] x_in;
        logic [63:0] r_in;
        logic [63:0] bitv;
        logic [64:0] trial;
        logic [63:0] x_next;
        logic [63:0] r_next;

        if (k == 0) begin : g_first
            assign x_in = x;
            assign r_in = '0;
        end
        else begin : g_rest
            assign x_in = x_reg[k-1];
            assign r_in = r_reg[k-1];
        end

        assign bitv  = 64'd1 << (2 * (ISQRT_STAGES - 1 - k));
        assign trial = {1'b0, r_in} + {1'b0, bitv};

        always_comb
        begin
            if ({1'b0, x_in} >= trial)
            begin
                x_next = x_in - trial[63:0];
                r_next = (r_in >> 1) + bitv;
            end
            else
            begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k] <= x_next;
                r_reg[k] <= r_next;
            end
        end
    end

    assign root = r_reg[ISQRT_STAGES-1][31:0];

endmodule

`default_nettype wire

@@ design/v3a_div.sv @@
// Pipelined restoring divider: 64-bit dividend by 32-bit divisor,
// 33 quotient bits plus a range flag. Depends on v3a_pkg.
`default_nettype none

module v3a_div (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [63:0]                    n,
    input  wire logic [31:0]                    d,
    output logic      [v3a_pkg::DIV_QBITS-1:0] q,
    output logic                                big
);
    import v3a_pkg::*;

    logic [63:0]          rem_reg [DIV_STAGES];
    logic [31:0]          d_reg   [DIV_STAGES];
    logic [DIV_QBITS-1:0] q_reg   [DIV_STAGES];
    logic                 big_reg [DIV_STAGES];

    // quotient too wide for the stages when n >= d * 2^33
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= n;
            d_reg[0]   <= d;
            q_reg[0]   <= '0;
            big_reg[0] <= (n >> DIV_QBITS) >= {32'd0, d};
        end
    end

    for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
        logic [63:0]          dsh;
        logic [63:0]          rem_next;
        logic [DIV_QBITS-1:0] q_next;

        assign dsh = {32'd0, d_reg[k-1]} << (DIV_QBITS - k);

        always_comb
        begin
            rem_next = rem_reg[k-1];
            q_next   = q_reg[k-1];
            if (rem_reg[k-1] >= dsh)
            begin
                rem_next = rem_reg[k-1] - dsh;
                q_next[DIV_QBITS-k] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                d_reg[k]   <= d_reg[k-1];
                q_reg[k]   <= q_next;
                big_reg[k] <= big_reg[k-1];
            end
        end
    end

    assign q   = q_reg[DIV_STAGES-1];
    assign big = big_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ design/v3a_checker.sv @@
// Port-level checks for the 3D vector unit, bound to the top level.
// Depends on v3a_pkg for fault codes.
`default_nettype none

module v3a_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata,
    input wire logic [1:0]   m_tuser
);
    import v3a_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // an empty output never blocks requests
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with output empty");

    a_fault: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == FAULT_NONE || m_tuser == FAULT_DIV0 || m_tuser == FAULT_OVF))
        else $error("bad fault code");

    a_div0: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == FAULT_DIV0 |-> m_tdata == 128'd0)
        else $error("divide fault with nonzero result");

endmodule

bind vector3_fixed_point_alu v3a_checker u_v3a_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/vector3_fixed_point_alu_test.sv @@
// Self-checking testbench for vector3_fixed_point_alu: directed table, then random requests,
// checked against table expectations or an in-bench Q16.16 predictor. Depends on v3a_pkg and the block's RTL.
`default_nettype none

module vector3_fixed_point_alu_test;
    import v3a_pkg::*;

    localparam int FB = V3A_FRAC_BITS;
    localparam int LATENCY = 71;
    localparam int N_RANDOM = 1800;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] s;
        logic [1:0]  f;
    } vres_t;

    typedef struct {
        logic [3:0]  kind;
        logic [31:0] a [3];
        logic [31:0] b [3];
        logic [31:0] s;
        bit          typed;
        vres_t       want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [223:0] s_tdata = '0;
    logic [3:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0] m_tuser;

    vres_t pending_results[$];
    int errors = 0;
    bit stim_done = 0;
    bit hold_off = 0;

    vector3_fixed_point_alu DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        #20000000;
        $display("vector3_fixed_point_alu test failed");
        $finish;
    end

    function automatic longint sat(input longint v, inout bit ovf);
        if (v > 64'sd2147483647)
        begin
            ovf = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            ovf = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // sum of products over 2^FB, rounded half up; 128-bit keeps the sum exact
    function automatic longint round_q(input logic signed [127:0] acc);
        logic signed [127:0] r;
        r = (acc + (128'sd1 <<< (FB - 1))) >>> FB;
        if (r > 128'sd9223372036854775807)
            return 64'sd9223372036854775807;
        if (r < -128'sd9223372036854775807)
            return -64'sd9223372036854775807;
        return longint'(r);
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic vres_t predict_vector_op(input logic [3:0] kind, input logic [31:0] ai [3],
                                                input logic [31:0] bi [3], input logic [31:0] si);
        longint a [3];
        longint b [3];
        longint s;
        longint v [3];
        longint sc;
        logic [63:0] sq;
        logic [63:0] m;
        bit ovf;
        bit div0;
        vres_t r;
        v = '{0, 0, 0};
        sc = 0;
        ovf = 0;
        div0 = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = longint'($signed(ai[i]));
            b[i] = longint'($signed(bi[i]));
        end
        s = longint'($signed(si));
        sq = 0;
        for (int i = 0; i < 3; i++)
            sq += 64'(a[i] * a[i]);
        case (kind)
            OP_ADD: for (int i = 0; i < 3; i++) v[i] = sat(a[i] + b[i], ovf);
            OP_SUB: for (int i = 0; i < 3; i++) v[i] = sat(a[i] - b[i], ovf);
            OP_NEG: for (int i = 0; i < 3; i++) v[i] = sat(-a[i], ovf);
            OP_SCALE: for (int i = 0; i < 3; i++) v[i] = sat(round_q(128'(a[i] * s)), ovf);
            OP_DIV:
                if (s == 0)
                    div0 = 1;
                else
                    for (int i = 0; i < 3; i++) v[i] = sat((a[i] <<< FB) / s, ovf);
            OP_DOT:
                sc = sat(round_q(128'(a[0] * b[0]) + 128'(a[1] * b[1]) + 128'(a[2] * b[2])),
                         ovf);
            OP_CROSS:
                for (int i = 0; i < 3; i++)
                    v[i] = sat(round_q(128'(a[(i+1)%3] * b[(i+2)%3])
                                       - 128'(a[(i+2)%3] * b[(i+1)%3])), ovf);
            OP_MAG:
            begin
                m = floor_sqrt(sq);
                if (m > 64'd2147483647)
                begin
                    ovf = 1;
                    sc = 2147483647;
                end
                else
                    sc = longint'(m);
            end
            OP_MAGSQ:
            begin
                m = (sq + (64'd1 << (FB - 1))) >> FB;
                if (m > 64'd2147483647)
                begin
                    ovf = 1;
                    sc = 2147483647;
                end
                else
                    sc = longint'(m);
            end
            OP_NORM:
            begin
                m = floor_sqrt(sq);
                if (m == 0)
                    div0 = 1;
                else
                    for (int i = 0; i < 3; i++) v[i] = sat((a[i] <<< FB) / longint'(m), ovf);
            end
            default: ;
        endcase
        if (div0)
        begin
            v = '{0, 0, 0};
            sc = 0;
        end
        r.x = v[0][31:0];
        r.y = v[1][31:0];
        r.z = v[2][31:0];
        r.s = sc[31:0];
        r.f = div0 ? FAULT_DIV0 : (ovf ? FAULT_OVF : FAULT_NONE);
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
            4, 5: return 32'(int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
            6, 7: return 32'(int'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(input row_t r);
        vres_t w;
        int g;
        w = r.typed ? r.want : predict_vector_op(r.kind, r.a, r.b, r.s);
        s_tuser <= r.kind;
        s_tdata <= {r.s, r.b[2], r.b[1], r.b[0], r.a[2], r.a[1], r.a[0]};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(w);
        @(negedge clk);
        g = gap_len();
        if (g != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    function automatic row_t mk(input logic [3:0] k, input logic [31:0] ax, ay, az,
                                input logic [31:0] bx, by, bz, input logic [31:0] s);
        row_t r;
        r.kind = k;
        r.a = '{ax, ay, az};
        r.b = '{bx, by, bz};
        r.s = s;
        r.typed = 0;
        r.want = '0;
        return r;
    endfunction

    function automatic row_t mk_typed(input row_t r, input vres_t w);
        r.typed = 1;
        r.want = w;
        return r;
    endfunction

    localparam logic [31:0] MAXP = 32'h7fff_ffff;
    localparam logic [31:0] MINN = 32'h8000_0000;
    localparam logic [31:0] ONE = 32'h0001_0000;

    // stimulus driver
    initial
    begin
        row_t dir_rows[$];
        row_t r;
        dir_rows.push_back(mk_typed(mk(OP_ADD, MAXP, MINN, ONE, ONE, MINN, ONE, 0),
                                    '{MAXP, MINN, 32'h0002_0000, 0, FAULT_OVF}));
        dir_rows.push_back(mk_typed(mk(OP_SUB, MINN, MAXP, 0, ONE, MINN, 0, 0),
                                    '{MINN, MAXP, 0, 0, FAULT_OVF}));
        dir_rows.push_back(mk_typed(mk(OP_NEG, MINN, ONE, 0, 0, 0, 0, 0),
                                    '{MAXP, 32'hffff_0000, 0, 0, FAULT_OVF}));
        dir_rows.push_back(mk_typed(mk(OP_DIV, ONE, ONE, ONE, 0, 0, 0, 0),
                                    '{0, 0, 0, 0, FAULT_DIV0}));
        dir_rows.push_back(mk_typed(mk(OP_NORM, 0, 0, 0, ONE, ONE, ONE, ONE),
                                    '{0, 0, 0, 0, FAULT_DIV0}));
        dir_rows.push_back(mk_typed(mk(4'd10, ONE, ONE, ONE, ONE, ONE, ONE, ONE), '0));
        dir_rows.push_back(mk_typed(mk(4'd15, MAXP, MINN, MAXP, MINN, MAXP, MINN, MINN), '0));
        dir_rows.push_back(mk_typed(mk(OP_MAG, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0),
                                    '{0, 0, 0, 32'h0005_0000, FAULT_NONE}));
        dir_rows.push_back(mk(OP_SCALE, MAXP, MINN, 32'h0000_8000, 0, 0, 0, MINN));
        dir_rows.push_back(mk(OP_SCALE, 32'h0000_0001, 32'hffff_ffff, 3, 0, 0, 0, 32'h0000_8000));
        dir_rows.push_back(mk(OP_DIV, MINN, MAXP, ONE, 0, 0, 0, 32'hffff_ffff));
        dir_rows.push_back(mk(OP_DIV, ONE, 32'hfffe_0000, 7, 0, 0, 0, 32'h0003_0000));
        dir_rows.push_back(mk(OP_DOT, MINN, MINN, MINN, MINN, MINN, MINN, 0));
        dir_rows.push_back(mk(OP_DOT, ONE, 32'h0002_0000, 32'hffff_8000, 1, 2, 3, 0));
        dir_rows.push_back(mk(OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0));
        dir_rows.push_back(mk(OP_CROSS, MAXP, MINN, MAXP, MINN, MAXP, MINN, 0));
        dir_rows.push_back(mk(OP_MAG, MINN, MINN, MINN, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_MAGSQ, MINN, MAXP, MINN, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_MAGSQ, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_NORM, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_NORM, MINN, MAXP, 5, 0, 0, 0, 0));

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (dir_rows[i])
            send_request(dir_rows[i]);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            r = mk($urandom_range(0, 99) < 95 ? 4'($urandom_range(0, 9)) : 4'($urandom),
                   rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                   rand_word(), rand_word());
            if (n == 600)
                hold_off = 1;
            if (n == 1200)
            begin
                // drain fully before continuing
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
            send_request(r);
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    // result taker
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (200) @(negedge clk);
                hold_off = 0;
            end
            g = gap_len();
            if (g > 3)
            begin
                m_tready <= 1'b0;
                repeat (g) @(negedge clk);
            end
            else
                m_tready <= (g == 0 || $urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        vres_t w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (m_tdata[31:0] !== w.x)
                begin
                    $error("res_x expected %h got %h", w.x, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== w.y)
                begin
                    $error("res_y expected %h got %h", w.y, m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] !== w.z)
                begin
                    $error("res_z expected %h got %h", w.z, m_tdata[95:64]);
                    errors++;
                end
                if (m_tdata[127:96] !== w.s)
                begin
                    $error("res_scalar expected %h got %h", w.s, m_tdata[127:96]);
                    errors++;
                end
                if (m_tuser !== w.f)
                begin
                    $error("fault expected %0d got %0d", w.f, m_tuser);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("vector3_fixed_point_alu test passed");
        else
            $display("vector3_fixed_point_alu test failed");
        $finish;
    end

endmodule

`default_nettype wire
